### rtl/interval_timer_statistics_core_assert.svh
// assertion macros used by the engine
`ifndef INTERVAL_TIMER_STATISTICS_CORE_ASSERT_SVH
`define INTERVAL_TIMER_STATISTICS_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ITS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ITS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/itstat_pkg.sv
`timescale 1ns / 1ps

package itstat_pkg;

    localparam int TIME_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int MEAN_BITS = TIME_BITS + FRAC_BITS;
    localparam int SUM_BITS  = 64;
    localparam int ALU_BITS  = MEAN_BITS + 1;
    localparam int STEP_BITS = 6;
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(MEAN_BITS - 1);

    typedef enum logic [2:0] {
        OP_START     = 3'd0,
        OP_PAUSE     = 3'd1,
        OP_STOP      = 3'd2,
        OP_CLEAR_ALL = 3'd3,
        OP_CLEAR_CUR = 3'd4,
        OP_SAMPLE    = 3'd5
    } op_t;

    // statistics snapshot handed from the engine to the output stage
    typedef struct packed {
        logic                 paused;
        logic                 running;
        logic [SUM_BITS-1:0]  m2;
        logic [MEAN_BITS-1:0] mean;
        logic [TIME_BITS-1:0] max_dur;
        logic [TIME_BITS-1:0] min_dur;
        logic [SUM_BITS-1:0]  total;
        logic [TIME_BITS-1:0] last_dur;
        logic [TIME_BITS-1:0] count;
    } result_t;

endpackage

### rtl/itstat_addsub.sv
`timescale 1ns / 1ps

module itstat_addsub
    import itstat_pkg::*;
(
    input  logic [ALU_BITS-1:0] a,
    input  logic [ALU_BITS-1:0] b,
    input  logic                sub,
    output logic [ALU_BITS:0]   sum
);

    // single adder, b inverted with carry-in for subtraction
    assign sum = {1'b0, a} + ({1'b0, b} ^ {(ALU_BITS + 1){sub}})
               + {{ALU_BITS{1'b0}}, sub};

endmodule

### rtl/itstat_engine.sv
`timescale 1ns / 1ps
`include "interval_timer_statistics_core_assert.svh"

module itstat_engine
    import itstat_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           in_op,
    input  logic [TIME_BITS-1:0] in_now,
    input  logic [TIME_BITS-1:0] in_begin,
    input  logic [TIME_BITS-1:0] in_end,
    input  logic                 out_free,
    output logic                 done,
    output result_t              res
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_REC, ST_DIV, ST_MEAN, ST_MAG, ST_MUL, ST_ACC, ST_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [2:0]           op_reg, op_next;
    logic [TIME_BITS-1:0] now_reg, now_next;
    logic [TIME_BITS-1:0] beg_reg, beg_next;
    logic [TIME_BITS-1:0] end_reg, end_next;
    logic                 running_reg, running_next;
    logic [TIME_BITS-1:0] start_reg, start_next;
    logic [TIME_BITS-1:0] acc_reg, acc_next;
    logic [TIME_BITS-1:0] count_reg, count_next;
    logic [TIME_BITS-1:0] latest_reg, latest_next;
    logic [TIME_BITS-1:0] last_reg, last_next;
    logic [SUM_BITS-1:0]  total_reg, total_next;
    logic [MEAN_BITS-1:0] mean_reg, mean_next;
    logic [SUM_BITS-1:0]  m2_reg, m2_next;
    logic [TIME_BITS-1:0] min_reg, min_next;
    logic [TIME_BITS-1:0] max_reg, max_next;
    logic [TIME_BITS-1:0] d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [MEAN_BITS-1:0] mag1_reg, mag1_next;
    logic [MEAN_BITS-1:0] quo_reg, quo_next;
    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [MEAN_BITS-1:0] hi_reg, hi_next;
    logic [MEAN_BITS-1:0] lo_reg, lo_next;
    logic [STEP_BITS-1:0] step_reg, step_next;

    logic [ALU_BITS-1:0]  unit_a, unit_b;
    logic                 unit_sub;
    logic [ALU_BITS:0]    unit_sum;

    logic [TIME_BITS:0]   run_sum;
    logic [TIME_BITS-1:0] run_dur;
    logic [TIME_BITS-1:0] sample_dur;
    logic [MEAN_BITS-1:0] x_val;
    logic                 x_neg;
    logic [TIME_BITS:0]   rem_sh;
    logic                 div_ge;
    logic [SUM_BITS:0]    total_sum;
    logic [SUM_BITS:0]    m2_sum;
    logic [SUM_BITS-1:0]  prod_sh;

    // shared add / subtract unit
    itstat_addsub u_addsub (
        .a   (unit_a),
        .b   (unit_b),
        .sub (unit_sub),
        .sum (unit_sum)
    );

    // helpers
    assign run_sum    = {1'b0, acc_reg} + {1'b0, now_reg - start_reg};
    assign run_dur    = run_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : run_sum[TIME_BITS-1:0];
    assign sample_dur = end_reg - beg_reg;
    assign x_val      = {d_reg, {FRAC_BITS{1'b0}}};
    assign x_neg      = x_val < mean_reg;
    assign rem_sh     = {rem_reg, quo_reg[MEAN_BITS-1]};
    assign div_ge     = !unit_sum[ALU_BITS];
    assign total_sum  = {1'b0, total_reg} + {{(SUM_BITS - TIME_BITS + 1){1'b0}}, d_reg};
    assign prod_sh    = {hi_reg, lo_reg[MEAN_BITS-1:2*FRAC_BITS]};
    assign m2_sum     = {1'b0, m2_reg} + {1'b0, prod_sh};

    assign in_ready = (state_reg == ST_IDLE);

    // statistics snapshot
    always_comb
    begin
        res.count    = count_reg;
        res.last_dur = last_reg;
        res.total    = total_reg;
        res.min_dur  = min_reg;
        res.max_dur  = max_reg;
        res.mean     = mean_reg;
        res.m2       = m2_reg;
        res.running  = running_reg;
        res.paused   = !running_reg && (acc_reg != '0);
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        now_next     = now_reg;
        beg_next     = beg_reg;
        end_next     = end_reg;
        running_next = running_reg;
        start_next   = start_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        latest_next  = latest_reg;
        last_next    = last_reg;
        total_next   = total_reg;
        mean_next    = mean_reg;
        m2_next      = m2_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        d_next       = d_reg;
        neg_next     = neg_reg;
        mag1_next    = mag1_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        step_next    = step_reg;
        unit_a       = '0;
        unit_b       = '0;
        unit_sub     = 1'b0;
        done         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_op;
                    now_next   = in_now;
                    beg_next   = in_begin;
                    end_next   = in_end;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_FIN;
                unique case (op_t'(op_reg))
                    OP_START:
                    begin
                        running_next = 1'b1;
                        start_next   = now_reg;
                    end
                    OP_PAUSE:
                    begin
                        if (running_reg)
                        begin
                            acc_next     = run_dur;
                            running_next = 1'b0;
                            start_next   = '0;
                        end
                    end
                    OP_STOP:
                    begin
                        if (running_reg || (acc_reg != '0))
                        begin
                            d_next       = running_reg ? run_dur : acc_reg;
                            last_next    = running_reg ? run_dur : acc_reg;
                            latest_next  = now_reg;
                            running_next = 1'b0;
                            start_next   = '0;
                            acc_next     = '0;
                            state_next   = ST_REC;
                        end
                    end
                    OP_CLEAR_ALL:
                    begin
                        running_next = 1'b0;
                        start_next   = '0;
                        acc_next     = '0;
                        count_next   = '0;
                        latest_next  = '0;
                        last_next    = '0;
                        total_next   = '0;
                        mean_next    = '0;
                        m2_next      = '0;
                        min_next     = '1;
                        max_next     = '0;
                    end
                    OP_CLEAR_CUR:
                    begin
                        running_next = 1'b0;
                        start_next   = '0;
                        acc_next     = '0;
                    end
                    OP_SAMPLE:
                    begin
                        d_next = sample_dur;
                        if (latest_reg < end_reg)
                        begin
                            latest_next = end_reg;
                            last_next   = sample_dur;
                        end
                        state_next = ST_REC;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_REC:
            begin
                if (count_reg != '1)
                    count_next = count_reg + 1'b1;
                total_next = total_sum[SUM_BITS] ? '1 : total_sum[SUM_BITS-1:0];
                if (d_reg < min_reg)
                    min_next = d_reg;
                if (d_reg > max_reg)
                    max_next = d_reg;
                // magnitude of x - mean
                neg_next   = x_neg;
                unit_a     = x_neg ? {1'b0, mean_reg} : {1'b0, x_val};
                unit_b     = x_neg ? {1'b0, x_val} : {1'b0, mean_reg};
                unit_sub   = 1'b1;
                mag1_next  = unit_sum[MEAN_BITS-1:0];
                quo_next   = unit_sum[MEAN_BITS-1:0];
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                unit_a    = {{(ALU_BITS - TIME_BITS - 1){1'b0}}, rem_sh};
                unit_b    = {{(ALU_BITS - TIME_BITS){1'b0}}, count_reg};
                unit_sub  = 1'b1;
                rem_next  = div_ge ? unit_sum[TIME_BITS-1:0] : rem_sh[TIME_BITS-1:0];
                quo_next  = {quo_reg[MEAN_BITS-2:0], div_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_MEAN;
            end
            ST_MEAN:
            begin
                unit_a     = {1'b0, mean_reg};
                unit_b     = {1'b0, quo_reg};
                unit_sub   = neg_reg;
                mean_next  = unit_sum[MEAN_BITS-1:0];
                state_next = ST_MAG;
            end
            ST_MAG:
            begin
                unit_a     = neg_reg ? {1'b0, mean_reg} : {1'b0, x_val};
                unit_b     = neg_reg ? {1'b0, x_val} : {1'b0, mean_reg};
                unit_sub   = 1'b1;
                lo_next    = unit_sum[MEAN_BITS-1:0];
                hi_next    = '0;
                step_next  = '0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                // shift-add multiply, one multiplier bit per cycle
                unit_a    = {1'b0, hi_reg};
                unit_b    = lo_reg[0] ? {1'b0, mag1_reg} : '0;
                hi_next   = unit_sum[MEAN_BITS:1];
                lo_next   = {unit_sum[0], lo_reg[MEAN_BITS-1:1]};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                m2_next    = m2_sum[SUM_BITS] ? '1 : m2_sum[SUM_BITS-1:0];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            op_reg      <= '0;
            now_reg     <= '0;
            beg_reg     <= '0;
            end_reg     <= '0;
            running_reg <= 1'b0;
            start_reg   <= '0;
            acc_reg     <= '0;
            count_reg   <= '0;
            latest_reg  <= '0;
            last_reg    <= '0;
            total_reg   <= '0;
            mean_reg    <= '0;
            m2_reg      <= '0;
            min_reg     <= '1;
            max_reg     <= '0;
            d_reg       <= '0;
            neg_reg     <= 1'b0;
            mag1_reg    <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            hi_reg      <= '0;
            lo_reg      <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            now_reg     <= now_next;
            beg_reg     <= beg_next;
            end_reg     <= end_next;
            running_reg <= running_next;
            start_reg   <= start_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
            latest_reg  <= latest_next;
            last_reg    <= last_next;
            total_reg   <= total_next;
            mean_reg    <= mean_next;
            m2_reg      <= m2_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            d_reg       <= d_next;
            neg_reg     <= neg_next;
            mag1_reg    <= mag1_next;
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            step_reg    <= step_next;
        end
    end

    // checks
    `ITS_ASSERT_NOW(a_done_free, clk, rst_n, done, out_free, "result issued with output full")
    `ITS_ASSERT_NOW(a_div_nonzero, clk, rst_n, state_reg == ST_DIV, count_reg != '0,
        "division by zero count")
    `ITS_ASSERT_NOW(a_min_max, clk, rst_n, count_reg != '0, min_reg <= max_reg,
        "min above max")
    `ITS_ASSERT_NEXT(a_div_end, clk, rst_n, state_reg == ST_DIV && step_reg == LAST_STEP,
        state_reg == ST_MEAN, "division did not end on time")

endmodule

### rtl/interval_timer_statistics_core.sv
// sequence: a simple command passes through the prepare and finish states and then the
// output register; a recorded interval (stop or add sample) also runs a 48-step restoring
// divide and a 48-step shift-add multiply, which share one 49-bit adder
// throughput: one command in flight; the next is taken once the result is registered,
// and a result waits in the finish state while the output is full and m_tready is low
// reset (rst_n low, asynchronous) clears all statistics, min to all ones, timer idle
`timescale 1ns / 1ps

module interval_timer_statistics_core
    import itstat_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,   // op
    input  logic [95:0]  s_tdata,   // now_stamp, sample_begin, sample_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // sample_count, last_duration, total_duration, min_duration, max_duration,
    // mean_duration, squared_diff_sum, is_running, is_paused, zero pad
    output logic [311:0] m_tdata
);

    logic          out_free;
    logic          done;
    result_t       res;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [311:0]  m_tdata_reg, m_tdata_next;

    itstat_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tuser),
        .in_now   (s_tdata[31:0]),
        .in_begin (s_tdata[63:32]),
        .in_end   (s_tdata[95:64]),
        .out_free (out_free),
        .done     (done),
        .res      (res)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    // output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (done)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, res.paused, res.running, res.m2, res.mean, res.max_dur,
                             res.min_dur, res.total, res.last_dur, res.count};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
